// File: hdl/vn_pkg.sv
package vn_pkg;

  localparam int unsigned NCOMP  = 4;
  localparam int unsigned COMP_W = 16;
  localparam int unsigned SQ_W   = 2 * COMP_W - 1;        // |c|^2 <= 2^30
  localparam int unsigned SUM_W  = SQ_W + 2;              // four squares, <= 2^32
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned RAD_W  = 50;                    // even width >= SUM_W + FRAC_SHIFT
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned SQREM_W = ROOT_W + 1;
  localparam int unsigned Q_W    = 15;
  localparam int unsigned DIV_SHIFT = 22;
  localparam int unsigned DVD_W  = COMP_W + DIV_SHIFT;
  localparam int unsigned SUB_W  = ROOT_W + Q_W;
  localparam int unsigned OUT_W  = 16;

  localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(16384);

  localparam int unsigned FRONT_STG = 2;
  localparam int unsigned PIPE_STG  = FRONT_STG + ROOT_W + Q_W;

  typedef logic [COMP_W-1:0] mag_t;

endpackage

// File: hdl/vn_in_if.sv
interface vn_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] in_z;
  logic signed [15:0] in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
                output ready);
endinterface

// File: hdl/vn_out_if.sv
interface vn_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;
  logic was_zero;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output was_zero, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                input was_zero, output ready);
endinterface

// File: hdl/vn_sqrt.sv
module vn_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vn_pkg::RAD_W-1:0]   rad,
  output logic [vn_pkg::ROOT_W-1:0]  root
);
  import vn_pkg::*;

  logic [SQREM_W-1:0] rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0]  root_r [1:ROOT_W];
  logic [RAD_W-1:0]   rad_r  [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stg
    logic [SQREM_W-1:0] rem_i;
    logic [ROOT_W-1:0]  root_i;
    logic [RAD_W-1:0]   rad_i;
    logic [SQREM_W+1:0] cur;
    logic [SQREM_W+1:0] trial;
    logic               ge;

    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_rest
      assign rem_i  = rem_r[i];
      assign root_i = root_r[i];
      assign rad_i  = rad_r[i];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? SQREM_W'(cur - trial) : SQREM_W'(cur);
        root_r[i+1] <= {root_i[ROOT_W-2:0], ge};
        rad_r[i+1]  <= {rad_i[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[ROOT_W];

endmodule

// File: hdl/vn_div_lane.sv
module vn_div_lane (
  input  logic                       clk,
  input  logic                       en,
  input  vn_pkg::mag_t               mag,
  input  logic [vn_pkg::ROOT_W-1:0]  len,
  output logic [vn_pkg::Q_W-1:0]     quo
);
  import vn_pkg::*;

  logic [DVD_W-1:0]  rem_r [1:Q_W];
  logic [Q_W-1:0]    quo_r [1:Q_W];
  logic [ROOT_W-1:0] len_r [1:Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stg
    logic [DVD_W-1:0]  rem_i;
    logic [Q_W-1:0]    quo_i;
    logic [ROOT_W-1:0] len_i;
    logic [SUB_W-1:0]  sub;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_i = {mag, DIV_SHIFT'(0)};
      assign quo_i = '0;
      assign len_i = len;
    end else begin : g_rest
      assign rem_i = rem_r[i];
      assign quo_i = quo_r[i];
      assign len_i = len_r[i];
    end

    // quotient bit Q_W-1-i: try subtracting the length shifted to that weight
    assign sub = SUB_W'(len_i) << (Q_W - 1 - i);
    assign ge  = (SUB_W'(rem_i) >= sub);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? DVD_W'(rem_i - sub[DVD_W-1:0]) : rem_i;
        quo_r[i+1] <= {quo_i[Q_W-2:0], ge};
        len_r[i+1] <= len_i;
      end
    end
  end

  assign quo = quo_r[Q_W];

endmodule

// File: hdl/vec4_normalize_unit.sv
// channel | dir | handshake   | payload
// up      | in  | valid/ready | in_x, in_y, in_z, in_w (signed 16)
// dn      | out | valid/ready | out_x..out_w (Q1.14), was_zero
//
// One vector per cycle while the output is not stalled.
// The root takes 25 stages (one root bit each), then four divider lanes
// take 15 stages (one quotient bit each), then the output register.
// The whole pipeline holds when the output register is full and not taken.
// Synchronous reset clears the valid bits only.
module vec4_normalize_unit (
  input  logic clk,
  input  logic rst,
  vn_in_if.sink    up,
  vn_out_if.source dn
);
  import vn_pkg::*;

  logic en;
  logic vld [1:PIPE_STG];
  logic out_vld;

  assign en       = !out_vld || dn.ready;
  assign up.ready = en;

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= PIPE_STG; i++) vld[i] <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld[1] <= up.valid;
      for (int i = 2; i <= PIPE_STG; i++) vld[i] <= vld[i-1];
      out_vld <= vld[PIPE_STG];
    end
  end

  // front: magnitudes and squares, then the sum
  logic signed [COMP_W-1:0] comp [NCOMP];
  mag_t                     mag_in [NCOMP];
  mag_t                     mag1 [NCOMP];
  logic                     neg1 [NCOMP];
  logic [SQ_W-1:0]          sq1  [NCOMP];
  mag_t                     mag2 [NCOMP];
  logic                     neg2 [NCOMP];
  logic [SUM_W-1:0]         sum2;

  assign comp[0] = up.in_x;
  assign comp[1] = up.in_y;
  assign comp[2] = up.in_z;
  assign comp[3] = up.in_w;

  for (genvar c = 0; c < NCOMP; c++) begin : g_mag
    assign mag_in[c] = comp[c][COMP_W-1] ? COMP_W'(-comp[c]) : COMP_W'(comp[c]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) begin
        mag1[c] <= mag_in[c];
        neg1[c] <= comp[c][COMP_W-1];
        sq1[c]  <= SQ_W'(mag_in[c] * mag_in[c]);
        mag2[c] <= mag1[c];
        neg2[c] <= neg1[c];
      end
      sum2 <= SUM_W'(sq1[0]) + SUM_W'(sq1[1]) + SUM_W'(sq1[2]) + SUM_W'(sq1[3]);
    end
  end

  // length
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] len;

  assign rad = RAD_W'({sum2, FRAC_SHIFT'(0)});

  vn_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (len)
  );

  // carry magnitudes and signs alongside the root stages
  mag_t mag_sl [1:ROOT_W][NCOMP];
  logic neg_sl [1:ROOT_W][NCOMP];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) begin
        mag_sl[1][c] <= mag2[c];
        neg_sl[1][c] <= neg2[c];
        for (int s = 2; s <= ROOT_W; s++) begin
          mag_sl[s][c] <= mag_sl[s-1][c];
          neg_sl[s][c] <= neg_sl[s-1][c];
        end
      end
    end
  end

  // divider lanes
  logic [Q_W-1:0] quo [NCOMP];
  logic           neg_dl [1:Q_W][NCOMP];
  logic           zero_dl [1:Q_W];

  for (genvar c = 0; c < NCOMP; c++) begin : g_lane
    vn_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .mag (mag_sl[ROOT_W][c]),
      .len (len),
      .quo (quo[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_dl[1] <= (len == '0);
      for (int s = 2; s <= Q_W; s++) zero_dl[s] <= zero_dl[s-1];
      for (int c = 0; c < NCOMP; c++) begin
        neg_dl[1][c] <= neg_sl[ROOT_W][c];
        for (int s = 2; s <= Q_W; s++) neg_dl[s][c] <= neg_dl[s-1][c];
      end
    end
  end

  // merge: clamp, restore sign, force zero for a zero vector
  logic [Q_W-1:0]           qc  [NCOMP];
  logic signed [OUT_W-1:0]  res [NCOMP];
  logic signed [OUT_W-1:0]  res_r [NCOMP];
  logic                     zero_r;

  for (genvar c = 0; c < NCOMP; c++) begin : g_merge
    assign qc[c]  = (quo[c] > UNIT_ONE) ? UNIT_ONE : quo[c];
    assign res[c] = zero_dl[Q_W] ? '0 :
                    neg_dl[Q_W][c] ? OUT_W'(-{1'b0, qc[c]}) : OUT_W'({1'b0, qc[c]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) res_r[c] <= res[c];
      zero_r <= zero_dl[Q_W];
    end
  end

  assign dn.valid    = out_vld;
  assign dn.out_x    = res_r[0];
  assign dn.out_y    = res_r[1];
  assign dn.out_z    = res_r[2];
  assign dn.out_w    = res_r[3];
  assign dn.was_zero = zero_r;

endmodule

// File: hdl/vn_check.sv
module vn_check (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic signed [15:0] out_w,
  input logic              was_zero
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
                                && $stable(out_w) && $stable(was_zero))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_zero |-> out_x == 0 && out_y == 0 && out_z == 0 && out_w == 0)
    else $error("zero vector gave nonzero result");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_x <= 16384 && out_x >= -16384 && out_y <= 16384 && out_y >= -16384
                  && out_z <= 16384 && out_z >= -16384 && out_w <= 16384 && out_w >= -16384)
    else $error("component beyond unit range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vec4_normalize_unit vn_check u_vn_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dn.valid),
  .out_ready (dn.ready),
  .out_x     (dn.out_x),
  .out_y     (dn.out_y),
  .out_z     (dn.out_z),
  .out_w     (dn.out_w),
  .was_zero  (dn.was_zero)
);

// File: tb/vec4_normalize_unit_tb.sv
`timescale 1ns / 1ps

module vec4_normalize_unit_tb;
  import vn_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
    logic               zero;
  } unit_vec_t;

  localparam int LATENCY   = 43;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vn_in_if  up ();
  vn_out_if dn ();

  vec4_normalize_unit dut (.clk(clk), .rst(rst), .up(up), .dn(dn));

  always #5 clk = ~clk;

  vec_t      pending_vecs[$];
  unit_vec_t expected_units[$];
  int        mismatches = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_cycles = 0;
  bit        hold_req = 1'b0;
  bit        pause_req = 1'b0;
  int        idle_cycles = 0;

  function automatic logic [24:0] int_sqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem  = n;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[24:0];
  endfunction

  function automatic logic signed [15:0] scale_comp(input logic signed [15:0] c,
                                                    input logic [24:0] len);
    logic [16:0] m;
    logic [63:0] q;
    m = c[15] ? 17'(-$signed({c[15], c})) : 17'(c);
    q = (64'(m) << 22) / 64'(len);
    if (q > 64'd16384) q = 64'd16384;
    return c[15] ? -$signed(16'(q)) : $signed(16'(q));
  endfunction

  function automatic unit_vec_t normalize(input vec_t v);
    unit_vec_t r;
    logic [63:0] sumsq;
    logic [24:0] len;
    sumsq = 64'($signed(v.x) * $signed(v.x)) + 64'($signed(v.y) * $signed(v.y))
          + 64'($signed(v.z) * $signed(v.z)) + 64'($signed(v.w) * $signed(v.w));
    len = int_sqrt(sumsq << 16);
    if (len == 0) begin
      r = '0;
      r.zero = 1'b1;
    end else begin
      r.x = scale_comp(v.x, len);
      r.y = scale_comp(v.y, len);
      r.z = scale_comp(v.z, len);
      r.w = scale_comp(v.w, len);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [15:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(0, 3)) - 16'd1);
      3: return $signed(16'($urandom_range(0, 255)) - 16'd128);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic report(input string what, input logic signed [15:0] got,
                        input logic signed [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      up.valid <= 1'b0;
    end else begin
      if (up.valid && up.ready) begin
        expected_units.push_back(normalize({up.in_x, up.in_y, up.in_z, up.in_w}));
        send_gap <= pick_gap();
      end
      if ((up.valid && !up.ready) ||
          (!(up.valid && up.ready) && up.valid)) begin
        // hold the request
      end else if (pending_vecs.size() != 0 && !pause_req &&
                   ((up.valid && up.ready) ? pick_gap() == 0 : send_gap == 0)) begin
        vec_t v;
        v = pending_vecs.pop_front();
        up.valid <= 1'b1;
        up.in_x <= v.x;
        up.in_y <= v.y;
        up.in_z <= v.z;
        up.in_w <= v.w;
      end else begin
        up.valid <= 1'b0;
        if (send_gap > 0 && !(up.valid && up.ready)) send_gap <= send_gap - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      dn.ready <= 1'b0;
    end else begin
      if (dn.valid && dn.ready) begin
        if (expected_units.size() == 0) begin
          report("unexpected out_x", dn.out_x, 16'sd0);
        end else begin
          unit_vec_t e;
          e = expected_units.pop_front();
          if (dn.out_x !== e.x) report("out_x", dn.out_x, e.x);
          if (dn.out_y !== e.y) report("out_y", dn.out_y, e.y);
          if (dn.out_z !== e.z) report("out_z", dn.out_z, e.z);
          if (dn.out_w !== e.w) report("out_w", dn.out_w, e.w);
          if (dn.was_zero !== e.zero) report("was_zero", 16'(dn.was_zero), 16'(e.zero));
        end
      end
      if (hold_req && hold_cycles == 0) begin
        hold_cycles <= 400;
        dn.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        dn.ready <= (hold_cycles == 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        dn.ready <= 1'b0;
      end else begin
        dn.ready <= 1'b1;
        if (dn.valid && dn.ready) recv_gap <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((up.valid && up.ready) || (dn.valid && dn.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("vec4_normalize_unit test failed");
      $finish;
    end
  end

  initial begin
    vec_t v;
    up.valid = 1'b0;
    up.in_x = '0;
    up.in_y = '0;
    up.in_z = '0;
    up.in_w = '0;
    dn.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero vector, axis extremes, full-scale mixes, small values
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sh7fff, 16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sh8000, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sh7fff, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sh8000});
    pending_vecs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_vecs.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_vecs.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    pending_vecs.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{-16'sd1, 16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd1, 16'sd1, 16'sd1, 16'sd1});
    pending_vecs.push_back('{-16'sd1, 16'sd1, -16'sd1, 16'sd1});
    pending_vecs.push_back('{16'sd3, 16'sd4, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd1, 16'sh7fff, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sh5555, -16'sh2aaa, 16'sd0, 16'sd0});
    for (int i = 0; i < 600; i++) begin
      v = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      pending_vecs.push_back(v);
    end

    // long receiver stall while the sender keeps offering
    repeat (300) @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;

    wait (pending_vecs.size() == 0);
    // let the pipeline drain completely before the next burst
    pause_req <= 1'b1;
    @(posedge clk);
    wait (expected_units.size() == 0 && !up.valid);
    repeat (LATENCY + 5) @(posedge clk);
    pause_req <= 1'b0;

    for (int i = 0; i < 1000; i++) begin
      v = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      pending_vecs.push_back(v);
    end
    wait (pending_vecs.size() == 0);
    @(posedge clk);
    wait (!up.valid && expected_units.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    if (mismatches == 0 && expected_units.size() == 0) begin
      $display("vec4_normalize_unit test passed");
    end else begin
      $display("vec4_normalize_unit test failed");
    end
    $finish;
  end

endmodule
